// ----- rtl/erfi_pkg.sv -----
// erfi_pkg: shared types, constants and helper functions for the binary32 erfinv pipeline
// no dependencies; used by every module under rtl
package erfi_pkg;

  localparam int FMA_LAT = 3;   // register stages in one fused multiply-add
  localparam int NLEV    = 23;  // chained arithmetic levels

  localparam logic [31:0] F_SIGN       = 32'h8000_0000;
  localparam logic [31:0] F_QBIT       = 32'h0040_0000;
  localparam logic [31:0] F_INF        = 32'h7F80_0000;
  localparam logic [31:0] F_NINF       = 32'hFF80_0000;
  localparam logic [31:0] F_DNAN       = 32'h7FC0_0000;
  localparam logic [31:0] F_ONE        = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ONE    = 32'hBF80_0000;
  localparam logic [31:0] F_NEG_ZERO   = 32'h8000_0000;
  localparam logic [31:0] F_NEG_HALF   = 32'hBF00_0000;
  localparam logic [31:0] F_TWO_THIRDS = 32'h3F2A_AAAB;
  localparam logic [31:0] F_LN2        = 32'h3F31_7218;
  localparam logic [31:0] F_SPLIT      = 32'h40C4_0000;

  // log1p minimax coefficients
  localparam logic [31:0] LOG_R0 = 32'hBE05_7000;
  localparam logic [31:0] LOG_T0 = 32'h3E10_4000;
  localparam logic [31:0] LOG_C1 = 32'hBDF8_CCB4;
  localparam logic [31:0] LOG_C2 = 32'h3E0F_2BA0;
  localparam logic [31:0] LOG_C3 = 32'hBE2A_D9B1;
  localparam logic [31:0] LOG_C4 = 32'h3E4C_EC59;
  localparam logic [31:0] LOG_C5 = 32'hBE7F_FF01;
  localparam logic [31:0] LOG_C6 = 32'h3EAA_AA7D;

  localparam logic [31:0] TAIL_POLY [9] = '{
    32'h2FA6F5A2, 32'h32FBE4D7, 32'h35A3F289, 32'h37EE53EF, 32'h39CE55C9,
    32'h3B46606F, 32'h3B9E5490, 32'hBE877FB3, 32'h3F570B52
  };
  localparam logic [31:0] CORE_POLY [10] = '{
    32'h31BAE000, 32'h3419DA01, 32'h35A4C919, 32'h33F29669, 32'hB86B85E8,
    32'hB91ADF48, 32'h3B17B200, 32'h3C3D0F28, 32'hBE6D9577, 32'h3F62DFC4
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] n;
    logic [31:0] tt;
    logic [31:0] m;
    logic [31:0] s;
    logic [31:0] i;
    logic [31:0] r;
    logic [31:0] t;
    logic [31:0] pc;
    logic [31:0] pt;
    logic [31:0] specv;
    logic        spec;
  } ctx_t;

  typedef struct packed {
    logic [31:0] m;
    logic [31:0] i;
    logic [31:0] specv;
    logic        spec;
  } lp_t;

  typedef struct packed {
    logic [23:0]        sig;
    logic signed [9:0]  exp;
  } split_t;

  function automatic logic f_is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic f_is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // finite nonzero x = sig * 2^exp, sig in [2^23, 2^24)
  function automatic split_t f_split(logic [31:0] x);
    split_t r;
    int     p;
    int     k;
    p = 0;
    for (int j = 0; j < 23; j++) begin
      if (x[j]) p = j;
    end
    if (x[30:23] == 8'd0) begin
      k = 23 - p;
      r.sig = {1'b0, x[22:0]} << k;
      r.exp = 10'(-149 - k);
    end else begin
      r.sig = {1'b1, x[22:0]};
      r.exp = 10'(int'(x[30:23]) - 150);
    end
    return r;
  endfunction

endpackage

// ----- rtl/erfi_fma.sv -----
// erfi_fma: three-stage binary32 fused multiply-add, round to nearest even, subnormals kept
// depends on erfi_pkg
module erfi_fma (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] y
);

  function automatic logic [63:0] shr_sticky(logic [63:0] v, int d);
    logic [63:0] mask;
    if (d <= 0) return v;
    if (d >= 64) return {63'd0, |v};
    mask = (64'd1 << d) - 64'd1;
    return (v >> d) | {63'd0, |(v & mask)};
  endfunction

  function automatic logic [31:0] round_pack(logic sign, logic [63:0] s, int e);
    int          p;
    int          sh;
    int          qe;
    int          be;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    p = 0;
    for (int j = 0; j < 64; j++) begin
      if (s[j]) p = j;
    end
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh <= 0) begin
      q = s << (-sh);
    end else if (sh >= 64) begin
      q = 64'd0;
    end else begin
      rem  = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q    = s >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    qe = e + sh;
    if (q == 64'd0) return {sign, 31'd0};
    if (q == 64'h100_0000) begin
      q  = q >> 1;
      qe = qe + 1;
    end
    if (q[23]) begin
      be = qe + 150;
      if (be >= 255) return {sign, 8'hFF, 23'd0};
      return {sign, 8'(be), q[22:0]};
    end
    return {sign, 8'd0, q[22:0]};
  endfunction

  // stage 1: special operands, unpack, multiply
  logic               s1_spec;
  logic [31:0]        s1_val;
  logic               s1_sp;
  logic               s1_sc;
  logic [47:0]        s1_prod;
  logic signed [11:0] s1_ex;
  logic [23:0]        s1_mc;
  logic signed [11:0] s1_ey;
  logic               s1_cz;

  logic              sp_c;
  logic              spec_c;
  logic [31:0]       val_c;
  erfi_pkg::split_t  ua;
  erfi_pkg::split_t  ub;
  erfi_pkg::split_t  uc;

  always_comb begin
    sp_c   = a[31] ^ b[31];
    spec_c = 1'b1;
    val_c  = 32'd0;
    ua     = erfi_pkg::f_split(a);
    ub     = erfi_pkg::f_split(b);
    uc     = erfi_pkg::f_split(c);
    if (erfi_pkg::f_is_nan(a)) begin
      val_c = a | erfi_pkg::F_QBIT;
    end else if (erfi_pkg::f_is_nan(b)) begin
      val_c = b | erfi_pkg::F_QBIT;
    end else if (erfi_pkg::f_is_nan(c)) begin
      val_c = c | erfi_pkg::F_QBIT;
    end else if (erfi_pkg::f_is_inf(a) || erfi_pkg::f_is_inf(b)) begin
      if (erfi_pkg::f_is_zero(a) || erfi_pkg::f_is_zero(b)) val_c = erfi_pkg::F_DNAN;
      else if (erfi_pkg::f_is_inf(c) && c[31] != sp_c) val_c = erfi_pkg::F_DNAN;
      else val_c = {sp_c, 8'hFF, 23'd0};
    end else if (erfi_pkg::f_is_inf(c)) begin
      val_c = c;
    end else if (erfi_pkg::f_is_zero(a) || erfi_pkg::f_is_zero(b)) begin
      if (!erfi_pkg::f_is_zero(c)) val_c = c;
      else val_c = (sp_c == c[31]) ? {sp_c, 31'd0} : 32'd0;
    end else begin
      spec_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec <= spec_c;
      s1_val  <= val_c;
      s1_sp   <= sp_c;
      s1_sc   <= c[31];
      s1_prod <= ua.sig * ub.sig;
      s1_ex   <= 12'(int'(ua.exp) + int'(ub.exp) - 13);
      s1_mc   <= uc.sig;
      s1_ey   <= 12'(int'(uc.exp) - 37);
      s1_cz   <= erfi_pkg::f_is_zero(c);
    end
  end

  // stage 2: align and add
  logic               s2_spec;
  logic [31:0]        s2_val;
  logic               s2_sign;
  logic [63:0]        s2_sum;
  logic signed [11:0] s2_e;

  logic [63:0]        x_c;
  logic [63:0]        y_c;
  logic [63:0]        sum_c;
  logic               sign_c;
  logic signed [11:0] e_c;
  logic               zero_c;

  always_comb begin
    x_c    = {3'd0, s1_prod, 13'd0};
    y_c    = {3'd0, s1_mc, 37'd0};
    e_c    = s1_ex;
    sum_c  = x_c;
    sign_c = s1_sp;
    zero_c = 1'b0;
    if (!s1_cz) begin
      if (s1_ex >= s1_ey) begin
        y_c = shr_sticky(y_c, int'(s1_ex) - int'(s1_ey));
      end else begin
        x_c = shr_sticky(x_c, int'(s1_ey) - int'(s1_ex));
        e_c = s1_ey;
      end
      if (s1_sp == s1_sc) begin
        sum_c = x_c + y_c;
      end else if (x_c == y_c) begin
        zero_c = 1'b1;
      end else if (x_c > y_c) begin
        sum_c = x_c - y_c;
      end else begin
        sum_c  = y_c - x_c;
        sign_c = s1_sc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_spec <= s1_spec | zero_c;
      s2_val  <= s1_spec ? s1_val : 32'd0;
      s2_sign <= sign_c;
      s2_sum  <= sum_c;
      s2_e    <= e_c;
    end
  end

  // stage 3: normalize and round
  always_ff @(posedge clk) begin
    if (en) begin
      y <= s2_spec ? s2_val : round_pack(s2_sign, s2_sum, int'(s2_e));
    end
  end

endmodule

// ----- rtl/erfi_log_prep.sv -----
// erfi_log_prep: log argument reduction (mantissa into [2/3, 4/3], exponent to float)
// and log special cases; three register stages to match erfi_fma; depends on erfi_pkg
module erfi_log_prep (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       x,
  output erfi_pkg::lp_t     lp
);

  function automatic logic [31:0] int_to_f(int v);
    logic        sign;
    logic [31:0] mag;
    logic [31:0] sh;
    int          p;
    if (v == 0) return 32'd0;
    sign = (v < 0);
    mag  = sign ? 32'(-v) : 32'(v);
    mag  = mag & 32'h0000_FFFF;
    p = 0;
    for (int j = 0; j < 16; j++) begin
      if (mag[j]) p = j;
    end
    sh = mag << (23 - p);
    return {sign, 8'(127 + p), sh[22:0]};
  endfunction

  erfi_pkg::lp_t    lp_c;
  erfi_pkg::lp_t    pipe [2];
  erfi_pkg::split_t u;
  int               e;

  always_comb begin
    u          = erfi_pkg::f_split(x);
    lp_c.spec  = 1'b1;
    lp_c.specv = 32'd0;
    if (erfi_pkg::f_is_nan(x)) lp_c.specv = x | erfi_pkg::F_QBIT;
    else if (erfi_pkg::f_is_zero(x)) lp_c.specv = erfi_pkg::F_NINF;
    else if (x[31]) lp_c.specv = erfi_pkg::F_DNAN;
    else if (x == erfi_pkg::F_INF) lp_c.specv = erfi_pkg::F_INF;
    else lp_c.spec = 1'b0;
    lp_c.m = 32'h3F00_0000 | {9'd0, u.sig[22:0]};
    e      = int'(u.exp) + 24;
    if (lp_c.m < erfi_pkg::F_TWO_THIRDS) begin
      lp_c.m = lp_c.m + 32'h0080_0000;
      e      = e - 1;
    end
    lp_c.i = int_to_f(e);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= lp_c;
      pipe[1] <= pipe[0];
      lp      <= pipe[1];
    end
  end

endmodule

// ----- rtl/erfi_ctx_dly.sv -----
// erfi_ctx_dly: carries the live operand set and valid bit alongside one arithmetic level
// depends on erfi_pkg
module erfi_ctx_dly (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_i,
  input  erfi_pkg::ctx_t ctx_i,
  output logic           vld_o,
  output erfi_pkg::ctx_t ctx_o
);

  logic [erfi_pkg::FMA_LAT-1:0] vld;
  erfi_pkg::ctx_t               ctx [erfi_pkg::FMA_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[erfi_pkg::FMA_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0] <= ctx_i;
      for (int j = 1; j < erfi_pkg::FMA_LAT; j++) begin
        ctx[j] <= ctx[j-1];
      end
    end
  end

  assign vld_o = vld[erfi_pkg::FMA_LAT-1];
  assign ctx_o = ctx[erfi_pkg::FMA_LAT-1];

endmodule

// ----- rtl/float32_inverse_erf_top.sv -----
// float32_inverse_erf_top: binary32 erfinv as a chain of 23 arithmetic levels
// 22 levels are fused multiply-adds and one is log prep; 3 register stages each
// one beat per cycle; all levels hold while a finished result is stalled at the output
// reset (rst, synchronous) clears the valid bits only; no state is kept between beats
// depends on erfi_pkg, erfi_fma, erfi_log_prep, erfi_ctx_dly
module float32_inverse_erf_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        a_valid,
  output logic        a_stall,
  input  logic [31:0] a_bits,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] result_bits
);

  localparam int NL = erfi_pkg::NLEV;

  erfi_pkg::ctx_t lc [NL+1];
  logic           lv [NL+1];
  erfi_pkg::ctx_t cd [NL];
  logic           en;

  assign en      = !(lv[NL] && result_stall);
  assign a_stall = !en;

  always_comb begin
    lc[0]   = '0;
    lc[0].a = a_bits;
  end
  assign lv[0] = a_valid;

  genvar gl;
  generate
    for (gl = 0; gl < NL; gl++) begin : g_dly
      erfi_ctx_dly u_dly (
        .clk(clk), .rst(rst), .en(en),
        .vld_i(lv[gl]), .ctx_i(lc[gl]),
        .vld_o(lv[gl+1]), .ctx_o(cd[gl])
      );
    end
  endgenerate

  // 1 - a*a
  logic [31:0] f0, f1;
  erfi_fma u_f0 (.clk(clk), .en(en), .a(32'd0), .b(erfi_pkg::F_ONE),
                 .c(lc[0].a ^ erfi_pkg::F_SIGN), .y(f0));
  always_comb begin
    lc[1]   = cd[0];
    lc[1].n = f0;
  end
  erfi_fma u_f1 (.clk(clk), .en(en), .a(lc[1].a), .b(lc[1].n),
                 .c(erfi_pkg::F_ONE), .y(f1));
  always_comb begin
    lc[2]    = cd[1];
    lc[2].tt = f1;
  end

  // log argument reduction
  erfi_pkg::lp_t lp;
  erfi_log_prep u_lp (.clk(clk), .en(en), .x(lc[2].tt), .lp(lp));
  always_comb begin
    lc[3]       = cd[2];
    lc[3].m     = lp.m;
    lc[3].i     = lp.i;
    lc[3].spec  = lp.spec;
    lc[3].specv = lp.specv;
  end

  logic [31:0] f3, f4, f5r, f5t, f6r, f6t, f7, f8, f9, f10, f11, f12;
  erfi_fma u_f3 (.clk(clk), .en(en), .a(lc[3].m), .b(erfi_pkg::F_ONE),
                 .c(erfi_pkg::F_NEG_ONE), .y(f3));
  always_comb begin
    lc[4]   = cd[3];
    lc[4].m = f3;
  end
  erfi_fma u_f4 (.clk(clk), .en(en), .a(lc[4].m), .b(lc[4].m),
                 .c(erfi_pkg::F_NEG_ZERO), .y(f4));
  always_comb begin
    lc[5]   = cd[4];
    lc[5].s = f4;
  end
  // odd and even halves of the log polynomial run side by side
  erfi_fma u_f5r (.clk(clk), .en(en), .a(erfi_pkg::LOG_R0), .b(lc[5].s),
                  .c(erfi_pkg::LOG_C1), .y(f5r));
  erfi_fma u_f5t (.clk(clk), .en(en), .a(erfi_pkg::LOG_T0), .b(lc[5].s),
                  .c(erfi_pkg::LOG_C2), .y(f5t));
  always_comb begin
    lc[6]   = cd[5];
    lc[6].r = f5r;
    lc[6].t = f5t;
  end
  erfi_fma u_f6r (.clk(clk), .en(en), .a(lc[6].r), .b(lc[6].s),
                  .c(erfi_pkg::LOG_C3), .y(f6r));
  erfi_fma u_f6t (.clk(clk), .en(en), .a(lc[6].t), .b(lc[6].s),
                  .c(erfi_pkg::LOG_C4), .y(f6t));
  always_comb begin
    lc[7]   = cd[6];
    lc[7].r = f6r;
    lc[7].t = f6t;
  end
  erfi_fma u_f7 (.clk(clk), .en(en), .a(lc[7].r), .b(lc[7].s),
                 .c(erfi_pkg::LOG_C5), .y(f7));
  always_comb begin
    lc[8]   = cd[7];
    lc[8].r = f7;
  end
  erfi_fma u_f8 (.clk(clk), .en(en), .a(lc[8].t), .b(lc[8].m), .c(lc[8].r), .y(f8));
  always_comb begin
    lc[9]   = cd[8];
    lc[9].r = f8;
  end
  erfi_fma u_f9 (.clk(clk), .en(en), .a(lc[9].r), .b(lc[9].m),
                 .c(erfi_pkg::LOG_C6), .y(f9));
  always_comb begin
    lc[10]   = cd[9];
    lc[10].r = f9;
  end
  erfi_fma u_f10 (.clk(clk), .en(en), .a(lc[10].r), .b(lc[10].m),
                  .c(erfi_pkg::F_NEG_HALF), .y(f10));
  always_comb begin
    lc[11]   = cd[10];
    lc[11].r = f10;
  end
  erfi_fma u_f11 (.clk(clk), .en(en), .a(lc[11].r), .b(lc[11].s), .c(lc[11].m), .y(f11));
  always_comb begin
    lc[12]   = cd[11];
    lc[12].r = f11;
  end
  // add exponent * ln2, special log values override
  erfi_fma u_f12 (.clk(clk), .en(en), .a(lc[12].i), .b(erfi_pkg::F_LN2),
                  .c(lc[12].r), .y(f12));
  always_comb begin
    lc[13]   = cd[12];
    lc[13].t = cd[12].spec ? cd[12].specv : f12;
  end

  // both polynomials in t; the tail one starts a level later
  generate
    for (gl = 13; gl < 22; gl++) begin : g_poly
      logic [31:0]    pc_n;
      erfi_pkg::ctx_t nx;
      erfi_fma u_pc (.clk(clk), .en(en),
                     .a((gl == 13) ? erfi_pkg::CORE_POLY[0] : lc[gl].pc),
                     .b(lc[gl].t), .c(erfi_pkg::CORE_POLY[gl-12]), .y(pc_n));
      if (gl >= 14) begin : g_tail
        logic [31:0] pt_n;
        erfi_fma u_pt (.clk(clk), .en(en),
                       .a((gl == 14) ? erfi_pkg::TAIL_POLY[0] : lc[gl].pt),
                       .b(lc[gl].t), .c(erfi_pkg::TAIL_POLY[gl-13]), .y(pt_n));
        always_comb begin
          nx    = cd[gl];
          nx.pc = pc_n;
          nx.pt = pt_n;
        end
      end else begin : g_core
        always_comb begin
          nx    = cd[gl];
          nx.pc = pc_n;
        end
      end
      assign lc[gl+1] = nx;
    end
  endgenerate

  // a times the selected polynomial
  logic [31:0] tmag, psel, f22;
  assign tmag = {1'b0, lc[22].t[30:0]};
  assign psel = (tmag <= erfi_pkg::F_INF && tmag > erfi_pkg::F_SPLIT) ? lc[22].pt : lc[22].pc;
  erfi_fma u_f22 (.clk(clk), .en(en), .a(lc[22].a), .b(psel),
                  .c(erfi_pkg::F_NEG_ZERO), .y(f22));
  always_comb begin
    lc[23]   = cd[22];
    lc[23].r = f22;
  end

  assign result_valid = lv[NL];
  assign result_bits  = lc[NL].r;

endmodule

// ----- tb/erfinv_checker.sv -----
// erfinv_checker: watches both channels of float32_inverse_erf_top, predicts erfinv per beat
// and compares each result beat with the oldest prediction; depends on erfi_pkg for constants
module erfinv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        a_valid,
  input  logic        a_stall,
  input  logic [31:0] a_bits,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] result_bits,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  logic [31:0] erfinv_due[$];

  function automatic logic is_nan32(logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_inf32(logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic is_zero32(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // normalized significand in [2^23, 2^24) and its power of two
  function automatic void unpack32(input logic [31:0] x, output logic [23:0] sig,
                                   output int ex);
    logic [23:0] f;
    int k;
    f = {1'b0, x[22:0]};
    k = 0;
    if (x[30:23] == 8'd0) begin
      while (!f[23]) begin
        f = f << 1;
        k++;
      end
      sig = f;
      ex = -149 - k;
    end else begin
      sig = {1'b1, x[22:0]};
      ex = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [63:0] shift_jam(logic [63:0] v, int d);
    if (d <= 0) return v;
    if (d >= 64) return (v != 0) ? 64'd1 : 64'd0;
    return (v >> d) | ((v & ((64'd1 << d) - 1)) != 0 ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [31:0] round_even32(logic [31:0] sign, logic [63:0] s, int e);
    int p, sh, qe, be;
    logic [63:0] q, rem, half;
    p = 63;
    while (!s[p]) p--;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh <= 0) begin
      q = s << (-sh);
    end else if (sh >= 64) begin
      q = 0;
    end else begin
      rem = s & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q = s >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    qe = e + sh;
    if (q == 0) return sign;
    if (q == 64'h100_0000) begin
      q = q >> 1;
      qe++;
    end
    if (q[23]) begin
      be = qe + 150;
      if (be >= 255) return sign | erfi_pkg::F_INF;
      return sign | (32'(be) << 23) | {9'd0, q[22:0]};
    end
    return sign | q[31:0];
  endfunction

  function automatic logic [31:0] fused32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] sp, sc;
    logic [23:0] ma, mb, mc;
    int ea, eb, ec, ex, ey, e;
    logic [63:0] x, y;
    sp = (a ^ b) & erfi_pkg::F_SIGN;
    sc = c & erfi_pkg::F_SIGN;
    if (is_nan32(a)) return a | erfi_pkg::F_QBIT;
    if (is_nan32(b)) return b | erfi_pkg::F_QBIT;
    if (is_nan32(c)) return c | erfi_pkg::F_QBIT;
    if (is_inf32(a) || is_inf32(b)) begin
      if (is_zero32(a) || is_zero32(b)) return erfi_pkg::F_DNAN;
      if (is_inf32(c) && sc != sp) return erfi_pkg::F_DNAN;
      return sp | erfi_pkg::F_INF;
    end
    if (is_inf32(c)) return c;
    if (is_zero32(a) || is_zero32(b)) begin
      if (!is_zero32(c)) return c;
      return (sp == sc) ? sp : 32'd0;
    end
    unpack32(a, ma, ea);
    unpack32(b, mb, eb);
    x = (64'(ma) * 64'(mb)) << 13;
    ex = ea + eb - 13;
    if (is_zero32(c)) return round_even32(sp, x, ex);
    unpack32(c, mc, ec);
    y = 64'(mc) << 37;
    ey = ec - 37;
    if (ex >= ey) begin
      y = shift_jam(y, ex - ey);
      e = ex;
    end else begin
      x = shift_jam(x, ey - ex);
      e = ey;
    end
    if (sp == sc) return round_even32(sp, x + y, e);
    if (x == y) return 32'd0;
    if (x > y) return round_even32(sp, x - y, e);
    return round_even32(sc, y - x, e);
  endfunction

  function automatic logic [31:0] int_to_f32(int v);
    logic [31:0] sign, mag;
    int p;
    if (v == 0) return 32'd0;
    sign = (v < 0) ? erfi_pkg::F_SIGN : 32'd0;
    mag = (v < 0) ? 32'(-v) : 32'(v);
    mag &= 32'hFFFF;
    p = 31;
    while (!mag[p]) p--;
    return sign | (32'(127 + p) << 23) | ((mag << (23 - p)) & 32'h7F_FFFF);
  endfunction

  function automatic logic [31:0] ln32(logic [31:0] a);
    logic [23:0] sig;
    logic [31:0] m, s, r, t, i;
    int e;
    if (is_nan32(a)) return a | erfi_pkg::F_QBIT;
    if (is_zero32(a)) return erfi_pkg::F_NINF;
    if (a[31]) return erfi_pkg::F_DNAN;
    if (a == erfi_pkg::F_INF) return erfi_pkg::F_INF;
    unpack32(a, sig, e);
    m = 32'h3F00_0000 | {9'd0, sig[22:0]};
    e += 24;
    // fold the mantissa into [2/3, 4/3]
    if (m < erfi_pkg::F_TWO_THIRDS) begin
      m += 32'h0080_0000;
      e--;
    end
    i = int_to_f32(e);
    m = fused32(m, erfi_pkg::F_ONE, erfi_pkg::F_NEG_ONE);
    s = fused32(m, m, erfi_pkg::F_NEG_ZERO);
    r = fused32(erfi_pkg::LOG_R0, s, erfi_pkg::LOG_C1);
    t = fused32(erfi_pkg::LOG_T0, s, erfi_pkg::LOG_C2);
    r = fused32(r, s, erfi_pkg::LOG_C3);
    t = fused32(t, s, erfi_pkg::LOG_C4);
    r = fused32(r, s, erfi_pkg::LOG_C5);
    r = fused32(t, m, r);
    r = fused32(r, m, erfi_pkg::LOG_C6);
    r = fused32(r, m, erfi_pkg::F_NEG_HALF);
    r = fused32(r, s, m);
    return fused32(i, erfi_pkg::F_LN2, r);
  endfunction

  function automatic logic [31:0] erfinv32(logic [31:0] a);
    logic [31:0] t, p, mag;
    t = fused32(a, fused32(32'd0, erfi_pkg::F_ONE, a ^ erfi_pkg::F_SIGN), erfi_pkg::F_ONE);
    t = ln32(t);
    mag = t & 32'h7FFF_FFFF;
    if (mag <= erfi_pkg::F_INF && mag > erfi_pkg::F_SPLIT) begin
      p = erfi_pkg::TAIL_POLY[0];
      for (int k = 1; k < 9; k++) p = fused32(p, t, erfi_pkg::TAIL_POLY[k]);
    end else begin
      p = erfi_pkg::CORE_POLY[0];
      for (int k = 1; k < 10; k++) p = fused32(p, t, erfi_pkg::CORE_POLY[k]);
    end
    return fused32(a, p, erfi_pkg::F_NEG_ZERO);
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      erfinv_due.delete();
      mismatches <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (a_valid && !a_stall) erfinv_due.push_back(erfinv32(a_bits));
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (erfinv_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat %h", result_bits);
          mismatches <= mismatches + 1;
        end else begin
          want = erfinv_due.pop_front();
          if (want !== result_bits) begin
            if (mismatches < 10)
              $display("result_bits mismatch: expected %h actual %h", want, result_bits);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= erfinv_due.size();
    end
  end

endmodule

// ----- tb/float32_inverse_erf_top_test.sv -----
// float32_inverse_erf_top_test: drives argument beats into float32_inverse_erf_top with random
// idling and a long output hold; depends on erfinv_checker and the rtl under test
module float32_inverse_erf_top_test;

  logic        clk;
  logic        rst;
  logic        a_valid;
  logic        a_stall;
  logic [31:0] a_bits;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] result_bits;
  int          mismatches;
  int          pending;
  int          results_seen;
  int          beats_sent;
  int          cycles;
  int          hold_left;
  logic        calm;
  logic        hold_done;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 800;

  float32_inverse_erf_top u_top (
    .clk(clk), .rst(rst), .a_valid(a_valid), .a_stall(a_stall), .a_bits(a_bits),
    .result_valid(result_valid), .result_stall(result_stall), .result_bits(result_bits)
  );

  erfinv_checker u_check (
    .clk(clk), .rst(rst), .a_valid(a_valid), .a_stall(a_stall), .a_bits(a_bits),
    .result_valid(result_valid), .result_stall(result_stall), .result_bits(result_bits),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // no idling on either side in the middle stretch
  assign calm = beats_sent >= 450 && beats_sent < 600;

  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold so the pipeline backs up
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_sent >= 200) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  function automatic logic [31:0] pick_arg();
    int kind;
    kind = $urandom_range(99);
    if (kind < 15) return $urandom();
    // magnitude in [0.125, 1), then at or just below one, where the tail polynomial takes over
    if (kind < 50) return {1'($urandom()), 8'(126 - $urandom_range(2)), 23'($urandom())};
    if (kind < 55) return {1'($urandom()), 31'h3F80_0000 - 31'($urandom_range(64))};
    if (kind < 60) return {1'($urandom()), 8'd0, 23'($urandom())};
    return {1'($urandom()), 8'($urandom_range(126)), 23'($urandom())};
  endfunction

  task automatic send_beat(logic [31:0] v);
    while (!calm && $urandom_range(99) < 17) begin
      a_valid <= 1'b0;
      @(posedge clk);
    end
    a_valid <= 1'b1;
    a_bits <= v;
    do @(posedge clk); while (a_stall);
    beats_sent++;
  endtask

  initial begin
    logic [31:0] directed[$];
    int settle;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                 32'hFFBF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                 32'h3F00_0000, 32'hBF00_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                 32'h3F80_0001, 32'h1E3C_E508, 32'h3F7F_F000, 32'h3F7E_0000,
                 32'h3DCC_CCCD, 32'hBF66_6666, 32'h3F6E_147B};
    beats_sent = 0;
    rst = 1'b1;
    a_valid = 1'b0;
    a_bits = 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) send_beat(directed[k]);
    repeat (RANDOM_BEATS) send_beat(pick_arg());
    a_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    settle = 0;
    while (settle < 100) begin
      @(posedge clk);
      settle++;
    end
    $display("%0d argument beats sent, %0d result beats checked, including specials and a long",
             beats_sent, results_seen);
    $display("output hold that backed the pipeline up to its input");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- float32_inverse_erf_top.f -----
rtl/erfi_pkg.sv
rtl/erfi_fma.sv
rtl/erfi_log_prep.sv
rtl/erfi_ctx_dly.sv
rtl/float32_inverse_erf_top.sv
tb/erfinv_checker.sv
tb/float32_inverse_erf_top_test.sv
